[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/d2q9_pkg.sv]
package d2q9_pkg;

	// Word format
	localparam int WORD_BITS  = 24;
	localparam int FRAC_BITS  = 20;
	localparam int DIRECTIONS = 9;
	localparam int RATE_BITS  = 21;

	// Internal widths
	localparam int SUM_W      = WORD_BITS + 4;
	localparam int MOM_W      = WORD_BITS + 3;
	localparam int MAG_W      = WORD_BITS + 2;
	localparam int CMP_W      = 2 * WORD_BITS - FRAC_BITS;
	localparam int REM_W      = MAG_W + FRAC_BITS;
	localparam int DIV_STAGES = WORD_BITS;
	localparam int BIT_IDX_W  = $clog2(WORD_BITS);
	localparam int PROD_W     = 2 * WORD_BITS;
	localparam int SQ_W       = 2 * WORD_BITS - 1;
	localparam int USQ_W      = SQ_W + 1 - FRAC_BITS;
	localparam int HALF_W     = SQ_W - FRAC_BITS - 1;
	localparam int PSUM_W     = USQ_W + 3;
	localparam int TDOT_W     = WORD_BITS + 4;
	localparam int FEQ0_W     = PROD_W - FRAC_BITS;
	localparam int M_W        = FEQ0_W + 2;
	localparam int WT_DIV     = 9;
	localparam int RECIP_SHIFT = M_W + 4;
	localparam int RECIP_W    = RECIP_SHIFT - 3;
	localparam int QEST_W     = M_W - 3;
	localparam int DIFF_W     = WORD_BITS + 1;
	localparam int RPROD_W    = RATE_BITS + 1 + DIFF_W;
	localparam int SCALED_W   = RPROD_W - FRAC_BITS;
	localparam int SAT_W      = 64;

	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / WT_DIV);

	// APB register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_RELAX_RATE = '0;
	localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(64'd1 << FRAC_BITS);

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [DIRECTIONS-1:0][WORD_BITS-1:0] dist_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// Lattice vectors, order rest, E, N, W, S, NE, NW, SW, SE
	localparam int DIR_X [DIRECTIONS] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
	localparam int DIR_Y [DIRECTIONS] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

	typedef enum logic [1:0] {WT_REST, WT_AXIS, WT_DIAG} wclass_t;
	localparam wclass_t WT_CLASS [DIRECTIONS] = '{WT_REST, WT_AXIS, WT_AXIS, WT_AXIS,
		WT_AXIS, WT_DIAG, WT_DIAG, WT_DIAG, WT_DIAG};

	// Node data carried through the divider
	typedef struct packed {
		dist_t f;
		word_t rho;
		logic  neg_x;
		logic  neg_y;
		logic  ovf_x;
		logic  ovf_y;
		logic  pos;
	} div_side_t;

	// Divider working values
	typedef struct packed {
		logic [REM_W-1:0]     rem_x;
		logic [REM_W-1:0]     rem_y;
		logic [WORD_BITS-1:0] q_x;
		logic [WORD_BITS-1:0] q_y;
	} div_work_t;

	// Node values after the velocities are known
	typedef struct packed {
		dist_t f;
		word_t rho;
		word_t ux;
		word_t uy;
	} node_t;

	function automatic word_t sat_word(input logic signed [SAT_W-1:0] x);
		word_t r;
		if (x > SAT_W'(WORD_MAX)) begin
			r = WORD_MAX;
		end else if (x < SAT_W'(WORD_MIN)) begin
			r = WORD_MIN;
		end else begin
			r = x[WORD_BITS-1:0];
		end
		return r;
	endfunction

	// Clamp the quotient magnitude, apply sign, force zero for non-positive density
	function automatic word_t vel_word(input logic [WORD_BITS-1:0] q, input logic neg,
		input logic ovf, input logic pos);
		logic [WORD_BITS-1:0] lim;
		logic [WORD_BITS-1:0] mag;
		word_t r;
		lim = {1'b1, {(WORD_BITS-1){1'b0}}};
		mag = (ovf || q > lim) ? lim : q;
		if (!pos) begin
			r = '0;
		end else if (neg) begin
			r = -$signed(mag);
		end else if (mag == lim) begin
			r = WORD_MAX;
		end else begin
			r = $signed(mag);
		end
		return r;
	endfunction

endpackage

[rtl/core/d2q9_moments.sv]
module d2q9_moments (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  d2q9_pkg::dist_t       f,
	output logic                  out_vld,
	output d2q9_pkg::div_side_t   side,
	output d2q9_pkg::div_work_t   work
);
	import d2q9_pkg::*;

	logic signed [SUM_W-1:0] sum;
	logic signed [MOM_W-1:0] mx, my;
	logic                    vld_s1;
	dist_t                   f_s1;
	word_t                   rho_s1;
	logic signed [MOM_W-1:0] mx_s1, my_s1;
	logic [MAG_W-1:0]        mag_x, mag_y;
	logic [CMP_W-1:0]        rho_lim;
	logic                    vld_s2;
	div_side_t               side_s2;
	div_work_t               work_s2;

	// Density and momentum sums
	always_comb begin
		sum = '0;
		mx  = '0;
		my  = '0;
		for (int k = 0; k < DIRECTIONS; k++) begin
			sum = sum + SUM_W'($signed(f[k]));
			if (DIR_X[k] == 1) begin
				mx = mx + MOM_W'($signed(f[k]));
			end else if (DIR_X[k] == -1) begin
				mx = mx - MOM_W'($signed(f[k]));
			end
			if (DIR_Y[k] == 1) begin
				my = my + MOM_W'($signed(f[k]));
			end else if (DIR_Y[k] == -1) begin
				my = my - MOM_W'($signed(f[k]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= f;
			rho_s1 <= sat_word(SAT_W'(sum));
			mx_s1  <= mx;
			my_s1  <= my;
		end
	end

	// Split sign and magnitude, detect quotients beyond the word
	always_comb begin
		mag_x   = MAG_W'(mx_s1 < 0 ? -mx_s1 : mx_s1);
		mag_y   = MAG_W'(my_s1 < 0 ? -my_s1 : my_s1);
		rho_lim = CMP_W'(rho_s1[WORD_BITS-2:0]) << (WORD_BITS - FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.f     <= f_s1;
			side_s2.rho   <= rho_s1;
			side_s2.neg_x <= mx_s1 < 0;
			side_s2.neg_y <= my_s1 < 0;
			side_s2.ovf_x <= CMP_W'(mag_x) >= rho_lim;
			side_s2.ovf_y <= CMP_W'(mag_y) >= rho_lim;
			side_s2.pos   <= rho_s1 > 0;
			work_s2.rem_x <= REM_W'(mag_x) << FRAC_BITS;
			work_s2.rem_y <= REM_W'(mag_y) << FRAC_BITS;
			work_s2.q_x   <= '0;
			work_s2.q_y   <= '0;
		end
	end

	assign out_vld = vld_s2;
	assign side    = side_s2;
	assign work    = work_s2;

endmodule

[rtl/core/d2q9_div_stage.sv]
module d2q9_div_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [d2q9_pkg::BIT_IDX_W-1:0]     bit_idx,
	input  logic                               in_vld,
	input  d2q9_pkg::div_side_t                side_in,
	input  d2q9_pkg::div_work_t                work_in,
	output logic                               out_vld,
	output d2q9_pkg::div_side_t                side,
	output d2q9_pkg::div_work_t                work
);
	import d2q9_pkg::*;

	logic [REM_W-1:0]     dshift;
	logic [WORD_BITS-1:0] qbit;
	div_work_t            nxt;
	logic                 vld_s1;
	div_side_t            side_s1;
	div_work_t            work_s1;

	// One restoring step per component
	always_comb begin
		dshift = REM_W'(side_in.rho[WORD_BITS-2:0]) << bit_idx;
		qbit   = WORD_BITS'(1) << bit_idx;
		nxt    = work_in;
		if (work_in.rem_x >= dshift) begin
			nxt.rem_x = work_in.rem_x - dshift;
			nxt.q_x   = work_in.q_x | qbit;
		end
		if (work_in.rem_y >= dshift) begin
			nxt.rem_y = work_in.rem_y - dshift;
			nxt.q_y   = work_in.q_y | qbit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			work_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign side    = side_s1;
	assign work    = work_s1;

endmodule

[rtl/core/d2q9_equil.sv]
module d2q9_equil (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  d2q9_pkg::div_side_t side,
	input  d2q9_pkg::div_work_t work,
	output logic                out_vld,
	output d2q9_pkg::node_t     node,
	output d2q9_pkg::dist_t     feq
);
	import d2q9_pkg::*;

	logic [6:0] vld_q;

	node_t node_s1, node_s2, node_s3, node_s4, node_s5, node_s6, node_s7;

	word_t                    t_c [DIRECTIONS];
	logic signed [TDOT_W-1:0] dot [DIRECTIONS];
	logic signed [PROD_W-1:0] px, py;
	word_t                    t_s2 [DIRECTIONS];
	logic [SQ_W-1:0]          sqx_s2, sqy_s2;

	logic [SQ_W:0]            sumsq;
	logic [USQ_W-1:0]         usq;
	logic signed [PROD_W-1:0] tt [DIRECTIONS];
	word_t                    t_s3 [DIRECTIONS];
	logic [HALF_W-1:0]        half_s3 [DIRECTIONS];
	logic [USQ_W:0]           usq3h_s3;

	logic signed [PSUM_W-1:0] psum [DIRECTIONS];
	word_t                    p_s4 [DIRECTIONS];

	logic signed [PROD_W-1:0] rp [DIRECTIONS];
	logic signed [FEQ0_W-1:0] feq0_s5 [DIRECTIONS];

	logic [FEQ0_W-1:0]          mag [DIRECTIONS];
	logic [M_W-1:0]             mw [DIRECTIONS];
	logic [M_W+RECIP_W-1:0]     est [DIRECTIONS];
	logic [M_W-1:0]             mw_s6 [DIRECTIONS];
	logic [QEST_W-1:0]          q_s6 [DIRECTIONS];
	logic [DIRECTIONS-1:0]      neg_s6;

	logic [M_W-1:0]           rem [DIRECTIONS];
	logic [QEST_W-1:0]        qa [DIRECTIONS];
	logic signed [QEST_W:0]   qs [DIRECTIONS];
	dist_t                    feq_s7;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[5:0], in_vld};
		end
	end

	// Stage 1: velocities from quotients
	always_ff @(posedge clk) begin
		if (en) begin
			node_s1.f   <= side.f;
			node_s1.rho <= side.rho;
			node_s1.ux  <= vel_word(work.q_x, side.neg_x, side.ovf_x, side.pos);
			node_s1.uy  <= vel_word(work.q_y, side.neg_y, side.ovf_y, side.pos);
		end
	end

	// Stage 2: squares of velocity, projected velocities
	always_comb begin
		px = node_s1.ux * node_s1.ux;
		py = node_s1.uy * node_s1.uy;
		for (int k = 0; k < DIRECTIONS; k++) begin
			dot[k] = '0;
			if (DIR_X[k] == 1) begin
				dot[k] = dot[k] + TDOT_W'(node_s1.ux);
			end else if (DIR_X[k] == -1) begin
				dot[k] = dot[k] - TDOT_W'(node_s1.ux);
			end
			if (DIR_Y[k] == 1) begin
				dot[k] = dot[k] + TDOT_W'(node_s1.uy);
			end else if (DIR_Y[k] == -1) begin
				dot[k] = dot[k] - TDOT_W'(node_s1.uy);
			end
			t_c[k] = sat_word(SAT_W'(dot[k] * TDOT_W'(3)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s2 <= node_s1;
			sqx_s2  <= px[SQ_W-1:0];
			sqy_s2  <= py[SQ_W-1:0];
			t_s2    <= t_c;
		end
	end

	// Stage 3: u squared term and t squared halves
	always_comb begin
		sumsq = (SQ_W+1)'(sqx_s2) + (SQ_W+1)'(sqy_s2);
		usq   = sumsq[SQ_W:FRAC_BITS];
		for (int k = 0; k < DIRECTIONS; k++) begin
			tt[k] = t_s2[k] * t_s2[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s3  <= node_s2;
			t_s3     <= t_s2;
			usq3h_s3 <= (USQ_W+1)'(((USQ_W+2)'(usq) * (USQ_W+2)'(3)) >> 1);
			for (int k = 0; k < DIRECTIONS; k++) begin
				half_s3[k] <= tt[k][SQ_W-1:FRAC_BITS+1];
			end
		end
	end

	// Stage 4: polynomial factor
	always_comb begin
		for (int k = 0; k < DIRECTIONS; k++) begin
			psum[k] = (PSUM_W'(1) <<< FRAC_BITS) + PSUM_W'(t_s3[k])
				+ PSUM_W'($signed({1'b0, half_s3[k]}))
				- PSUM_W'($signed({1'b0, usq3h_s3}));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s4 <= node_s3;
			for (int k = 0; k < DIRECTIONS; k++) begin
				p_s4[k] <= sat_word(SAT_W'(psum[k]));
			end
		end
	end

	// Stage 5: scale by density
	always_comb begin
		for (int k = 0; k < DIRECTIONS; k++) begin
			rp[k] = node_s4.rho * p_s4[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s5 <= node_s4;
			for (int k = 0; k < DIRECTIONS; k++) begin
				feq0_s5[k] <= rp[k][PROD_W-1:FRAC_BITS];
			end
		end
	end

	// Stage 6: weight and reciprocal estimate of the divide by nine
	always_comb begin
		for (int k = 0; k < DIRECTIONS; k++) begin
			mag[k] = FEQ0_W'(feq0_s5[k] < 0 ? -feq0_s5[k] : feq0_s5[k]);
			unique case (WT_CLASS[k])
				WT_REST: mw[k] = M_W'(mag[k]) << 2;
				WT_AXIS: mw[k] = M_W'(mag[k]);
				WT_DIAG: mw[k] = M_W'(mag[k] >> 2);
				default: mw[k] = '0;
			endcase
			est[k] = (M_W+RECIP_W)'(mw[k]) * (M_W+RECIP_W)'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s6 <= node_s5;
			for (int k = 0; k < DIRECTIONS; k++) begin
				mw_s6[k]  <= mw[k];
				q_s6[k]   <= QEST_W'(est[k] >> RECIP_SHIFT);
				neg_s6[k] <= feq0_s5[k] < 0;
			end
		end
	end

	// Stage 7: correct the estimate, restore sign
	always_comb begin
		for (int k = 0; k < DIRECTIONS; k++) begin
			rem[k] = mw_s6[k] - M_W'(q_s6[k]) * M_W'(WT_DIV);
			qa[k]  = (rem[k] >= M_W'(WT_DIV)) ? q_s6[k] + QEST_W'(1) : q_s6[k];
			qs[k]  = $signed({1'b0, qa[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s7 <= node_s6;
			for (int k = 0; k < DIRECTIONS; k++) begin
				feq_s7[k] <= sat_word(SAT_W'(neg_s6[k] ? -qs[k] : qs[k]));
			end
		end
	end

	assign out_vld = vld_q[6];
	assign node    = node_s7;
	assign feq     = feq_s7;

endmodule

[rtl/core/d2q9_relax.sv]
module d2q9_relax (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [d2q9_pkg::RATE_BITS-1:0]     relax_rate,
	input  logic                               in_vld,
	input  d2q9_pkg::node_t                    node_in,
	input  d2q9_pkg::dist_t                    feq,
	output logic                               out_vld,
	output d2q9_pkg::node_t                    node,
	output d2q9_pkg::dist_t                    g
);
	import d2q9_pkg::*;

	logic signed [DIFF_W-1:0]   diff [DIRECTIONS];
	logic signed [RPROD_W-1:0]  rprod [DIRECTIONS];
	logic signed [SCALED_W-1:0] scaled_s1 [DIRECTIONS];
	node_t                      node_s1, node_s2;
	logic                       vld_s1, vld_s2;
	dist_t                      g_s2;

	// Relaxation product
	always_comb begin
		for (int k = 0; k < DIRECTIONS; k++) begin
			diff[k]  = DIFF_W'($signed(node_in.f[k])) - DIFF_W'($signed(feq[k]));
			rprod[k] = RPROD_W'($signed({1'b0, relax_rate})) * RPROD_W'(diff[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s1 <= node_in;
			for (int k = 0; k < DIRECTIONS; k++) begin
				scaled_s1[k] <= rprod[k][RPROD_W-1:FRAC_BITS];
			end
		end
	end

	// Subtract and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			node_s2 <= node_s1;
			for (int k = 0; k < DIRECTIONS; k++) begin
				g_s2[k] <= sat_word(SAT_W'((SCALED_W+1)'($signed(node_s1.f[k]))
					- (SCALED_W+1)'(scaled_s1[k])));
			end
		end
	end

	assign out_vld = vld_s2;
	assign node    = node_s2;
	assign g       = g_s2;

endmodule

[rtl/core/d2q9_bgk_node_collision.sv]
// D2Q9 BGK collision engine, one lattice node per transfer.
// Input channel: in_valid/in_stall with the nine distributions f_* (signed
// Q3.20, order rest, E, N, W, S, NE, NW, SW, SE). Output channel:
// out_valid/out_stall with density, the two velocities and the nine
// collided distributions g_*, all signed Q3.20 and saturated.
// relax_rate (omega, unsigned Q1.20) sits at APB address 0; write it only
// while no node is in flight. pready is tied high.
// An accepted input passes the moments stages, the 24-stage restoring divider
// for the velocities, the equilibrium and relaxation stages and the output
// register. Throughput is one node per cycle while out_stall stays low.
// Reset clears all valid bits and loads omega with 1.0.
// When the receiver stalls, the result holds in the output register, the
// next one lands in a skid register, and only then does the pipeline freeze
// and in_stall rise; nothing is dropped or repeated.
`include "assert_macros.svh"

module d2q9_bgk_node_collision (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [d2q9_pkg::PADDR_W-1:0]     paddr,
	input  logic [d2q9_pkg::PDATA_W-1:0]     pwdata,
	output logic [d2q9_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  d2q9_pkg::word_t                  f_rest,
	input  d2q9_pkg::word_t                  f_east,
	input  d2q9_pkg::word_t                  f_north,
	input  d2q9_pkg::word_t                  f_west,
	input  d2q9_pkg::word_t                  f_south,
	input  d2q9_pkg::word_t                  f_northeast,
	input  d2q9_pkg::word_t                  f_northwest,
	input  d2q9_pkg::word_t                  f_southwest,
	input  d2q9_pkg::word_t                  f_southeast,
	output logic                             out_valid,
	input  logic                             out_stall,
	output d2q9_pkg::word_t                  density,
	output d2q9_pkg::word_t                  x_velocity,
	output d2q9_pkg::word_t                  y_velocity,
	output d2q9_pkg::word_t                  g_rest,
	output d2q9_pkg::word_t                  g_east,
	output d2q9_pkg::word_t                  g_north,
	output d2q9_pkg::word_t                  g_west,
	output d2q9_pkg::word_t                  g_south,
	output d2q9_pkg::word_t                  g_northeast,
	output d2q9_pkg::word_t                  g_northwest,
	output d2q9_pkg::word_t                  g_southwest,
	output d2q9_pkg::word_t                  g_southeast
);
	import d2q9_pkg::*;

	logic [RATE_BITS-1:0] relax_rate_q;
	logic                 cfg_wr;
	logic                 en;
	dist_t                f_in;

	logic      div_vld  [DIV_STAGES+1];
	div_side_t div_side [DIV_STAGES+1];
	div_work_t div_work [DIV_STAGES+1];

	logic  eq_vld;
	node_t eq_node;
	dist_t eq_feq;
	logic  rx_vld;
	node_t rx_node;
	dist_t rx_g;

	logic  out_valid_q, skid_valid_q, out_take;
	node_t out_node_q, skid_node_q;
	dist_t out_g_q, skid_g_q;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_RELAX_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_rate_q <= RATE_RESET;
		end else if (cfg_wr) begin
			relax_rate_q <= pwdata[RATE_BITS-1:0];
		end
	end

	always_comb begin
		if (paddr[PADDR_W-1:2] == REG_RELAX_RATE) begin
			prdata = PDATA_W'(relax_rate_q);
		end else begin
			prdata = '0;
		end
	end

	// Pipeline moves while the skid register is free
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	assign f_in = {f_southeast, f_southwest, f_northwest, f_northeast, f_south,
		f_west, f_north, f_east, f_rest};

	d2q9_moments u_moments (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.f       (f_in),
		.out_vld (div_vld[0]),
		.side    (div_side[0]),
		.work    (div_work[0])
	);

	// Restoring divider, one quotient bit per stage, MSB first
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		d2q9_div_stage u_div_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.bit_idx (BIT_IDX_W'(DIV_STAGES - 1 - i)),
			.in_vld  (div_vld[i]),
			.side_in (div_side[i]),
			.work_in (div_work[i]),
			.out_vld (div_vld[i+1]),
			.side    (div_side[i+1]),
			.work    (div_work[i+1])
		);
	end

	d2q9_equil u_equil (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (div_vld[DIV_STAGES]),
		.side    (div_side[DIV_STAGES]),
		.work    (div_work[DIV_STAGES]),
		.out_vld (eq_vld),
		.node    (eq_node),
		.feq     (eq_feq)
	);

	d2q9_relax u_relax (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.relax_rate (relax_rate_q),
		.in_vld     (eq_vld),
		.node_in    (eq_node),
		.feq        (eq_feq),
		.out_vld    (rx_vld),
		.node       (rx_node),
		.g          (rx_g)
	);

	// Output register with skid
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (rx_vld) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_node_q <= skid_node_q;
				out_g_q    <= skid_g_q;
			end
		end else if (rx_vld) begin
			if (!out_valid_q || out_take) begin
				out_node_q <= rx_node;
				out_g_q    <= rx_g;
			end else begin
				skid_node_q <= rx_node;
				skid_g_q    <= rx_g;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign density     = out_node_q.rho;
	assign x_velocity  = out_node_q.ux;
	assign y_velocity  = out_node_q.uy;
	assign g_rest      = out_g_q[0];
	assign g_east      = out_g_q[1];
	assign g_north     = out_g_q[2];
	assign g_west      = out_g_q[3];
	assign g_south     = out_g_q[4];
	assign g_northeast = out_g_q[5];
	assign g_northwest = out_g_q[6];
	assign g_southwest = out_g_q[7];
	assign g_southeast = out_g_q[8];

	// Checks
	`ASSERT_IMPLY(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full without output")
	`ASSERT_NEXT(a_skid_drains, skid_valid_q && out_take, !skid_valid_q, "skid not drained")
	`ASSERT_NEXT(a_rate_held, !cfg_wr, $stable(relax_rate_q), "omega changed without write")
	`ASSERT_IMPLY(a_still_fluid, out_valid_q && (density <= 0),
		(x_velocity == 0) && (y_velocity == 0), "velocity with non-positive density")

endmodule
